// ===== rtl/bltm_pkg.sv =====
package bltm_pkg;

    localparam int BLTM_PROGRAM_DEPTH = 64;
    localparam int BLTM_TAPE_DEPTH    = 256;

    localparam int OPC_W    = 3;
    localparam int CELL_W   = 8;
    localparam int LIMIT_W  = 16;
    localparam int STEPS_W  = 17;
    localparam int STATUS_W = 3;
    localparam int LEN_W    = 7;
    localparam int USED_W   = 9;

    localparam logic [LIMIT_W-1:0] STEP_LIMIT_RESET = 16'd5000;

    typedef enum logic [OPC_W-1:0] {
        OP_INC   = 3'd0,
        OP_DEC   = 3'd1,
        OP_RIGHT = 3'd2,
        OP_LEFT  = 3'd3,
        OP_OPEN  = 3'd4,
        OP_CLOSE = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_HALT       = 3'd0,
        ST_LIMIT      = 3'd1,
        ST_LEFT_EDGE  = 3'd2,
        ST_RIGHT_EDGE = 3'd3,
        ST_UNBAL      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC,
        S_FIN
    } state_t;

    // bracket check result of the program as loaded so far
    typedef struct packed {
        logic unbalanced;
        logic open_left;
    } check_t;

endpackage

// ===== rtl/bltm_loader.sv =====
module bltm_loader
    import bltm_pkg::*;
#(
    parameter int PROGRAM_DEPTH = BLTM_PROGRAM_DEPTH,
    localparam int PW = $clog2(PROGRAM_DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load_en,
    input  logic [OPC_W-1:0]  opcode,
    input  logic              last,
    output logic [PW:0]       load_len,
    output check_t            check,
    output logic              pair_pending,
    input  logic [PW-1:0]     rd_addr,
    output logic [OPC_W-1:0]  prog_rd,
    output logic [PW-1:0]     open_jump,
    output logic [PW-1:0]     close_jump
);

    logic [OPC_W-1:0] prog_mem  [PROGRAM_DEPTH];
    logic [PW-1:0]    open_mem  [PROGRAM_DEPTH];
    logic [PW-1:0]    close_mem [PROGRAM_DEPTH];
    logic [PW-1:0]    stack_mem [PROGRAM_DEPTH];

    logic [PW:0]      count_reg, count_next;
    logic [PW:0]      nest_reg, nest_next;
    logic             unbal_reg, unbal_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [PW-1:0]    pend_pos_reg, pend_pos_next;
    logic [PW-1:0]    stk_rd_reg;
    logic [OPC_W-1:0] prog_rd_reg;
    logic [PW-1:0]    open_rd_reg, close_rd_reg;

    logic             store, push, pop, underflow;
    logic [PW-1:0]    pos;
    logic [PW:0]      nest_dec, count_after, nest_after;

    assign pos       = count_reg[PW-1:0];
    assign nest_dec  = nest_reg - 1'b1;
    assign store     = load_en && (count_reg < (PW+1)'(PROGRAM_DEPTH));
    assign push      = store && (opcode == OP_OPEN);
    assign pop       = store && (opcode == OP_CLOSE) && (nest_reg != '0);
    assign underflow = store && (opcode == OP_CLOSE) && (nest_reg == '0);

    always_comb
    begin
        count_after = store ? count_reg + 1'b1 : count_reg;
        nest_after  = push ? nest_reg + 1'b1 : (pop ? nest_dec : nest_reg);

        load_len         = count_after;
        check.unbalanced = unbal_reg | underflow;
        check.open_left  = (nest_after != '0);

        count_next      = count_after;
        nest_next       = nest_after;
        unbal_next      = unbal_reg | underflow;
        pend_valid_next = pop;
        pend_pos_next   = pos;
        if (load_en && last)
        begin
            count_next = '0;
            nest_next  = '0;
            unbal_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            nest_reg       <= '0;
            unbal_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_pos_reg   <= '0;
        end
        else
        begin
            count_reg      <= count_next;
            nest_reg       <= nest_next;
            unbal_reg      <= unbal_next;
            pend_valid_reg <= pend_valid_next;
            pend_pos_reg   <= pend_pos_next;
        end
    end

    // top of stack is read every cycle; a close pairs up in the cycle after it is stored
    always_ff @(posedge clk)
    begin
        if (store)
            prog_mem[pos] <= opcode;
        if (push)
            stack_mem[nest_reg[PW-1:0]] <= pos;
        stk_rd_reg <= stack_mem[nest_dec[PW-1:0]];
        if (pend_valid_reg)
        begin
            close_mem[pend_pos_reg] <= stk_rd_reg;
            open_mem[stk_rd_reg]    <= pend_pos_reg;
        end
        prog_rd_reg  <= prog_mem[rd_addr];
        open_rd_reg  <= open_mem[rd_addr];
        close_rd_reg <= close_mem[rd_addr];
    end

    assign pair_pending = pend_valid_reg;
    assign prog_rd      = prog_rd_reg;
    assign open_jump    = open_rd_reg;
    assign close_jump   = close_rd_reg;

endmodule

// ===== rtl/bracket_language_tape_machine_unit.sv =====
// Bracket-language tape machine. Opcodes load one beat per cycle while in_ready
// is high; brackets are paired on the fly. The beat with last set starts a
// bracket check and, if the program is balanced, a run on a tape of wrapping
// 8-bit cells that starts all zero. One result beat follows each last beat. Each
// step of the run is a fetch from the program memory, then an execute against
// the cached cell under the head. When the last beat closes a bracket, the
// first fetch waits until that pair lands in the jump table; an unbalanced
// program reports with no run. The tape needs no clearing pass: cells past the
// high-water mark of the head read as zero.
// in_ready is low from the last beat until the result is in the output
// register; step_limit must only be written while the block is idle.
module bracket_language_tape_machine_unit
    import bltm_pkg::*;
#(
    parameter int PROGRAM_DEPTH = BLTM_PROGRAM_DEPTH,
    parameter int TAPE_DEPTH    = BLTM_TAPE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [LIMIT_W-1:0]  cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OPC_W-1:0]    opcode,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [CELL_W-1:0]   cell_value,
    output logic [LEN_W-1:0]    program_length,
    output logic [USED_W-1:0]   cells_used,
    output logic [STEPS_W-1:0]  steps_used
);

    localparam int PW = $clog2(PROGRAM_DEPTH);
    localparam int TW = $clog2(TAPE_DEPTH);

    logic [CELL_W-1:0]  tape_mem [TAPE_DEPTH];
    logic [CELL_W-1:0]  tape_rd_reg;
    logic               tape_we;
    logic [TW-1:0]      tape_raddr;

    logic [LIMIT_W-1:0] step_limit_reg;

    state_t             state_reg, state_next;
    logic [PW:0]        ip_reg, ip_next;
    logic [PW:0]        len_reg, len_next;
    logic [TW-1:0]      head_reg, head_next;
    logic [TW-1:0]      hm_reg, hm_next;
    logic [CELL_W-1:0]  cell_reg, cell_next;
    logic               cell_ld_reg, cell_ld_next;
    logic [STEPS_W-1:0] steps_reg, steps_next;
    status_t            stat_reg, stat_next;

    logic               out_valid_reg, out_valid_next;
    status_t            status_out_reg, status_out_next;
    logic [CELL_W-1:0]  cell_out_reg, cell_out_next;
    logic [LEN_W-1:0]   len_out_reg, len_out_next;
    logic [USED_W-1:0]  used_out_reg, used_out_next;
    logic [STEPS_W-1:0] steps_out_reg, steps_out_next;

    logic               in_fire;
    logic [PW:0]        ld_len;
    check_t             ld_check;
    logic               pair_pending;
    logic [OPC_W-1:0]   prog_rd;
    logic [PW-1:0]      open_jump, close_jump;
    logic [PW:0]        ip_inc, ip_open, ip_close;
    logic [TW:0]        used_calc;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    bltm_loader #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH)
    ) u_loader (
        .clk          (clk),
        .rst_n        (rst_n),
        .load_en      (in_fire),
        .opcode       (opcode),
        .last         (last),
        .load_len     (ld_len),
        .check        (ld_check),
        .pair_pending (pair_pending),
        .rd_addr      (ip_reg[PW-1:0]),
        .prog_rd      (prog_rd),
        .open_jump    (open_jump),
        .close_jump   (close_jump)
    );

    assign ip_inc    = ip_reg + 1'b1;
    assign ip_open   = {1'b0, open_jump} + (PW+1)'(1);
    assign ip_close  = {1'b0, close_jump} + (PW+1)'(1);
    assign used_calc = {1'b0, hm_reg} + (TW+1)'(1);

    always_comb
    begin
        state_next      = state_reg;
        ip_next         = ip_reg;
        len_next        = len_reg;
        head_next       = head_reg;
        hm_next         = hm_reg;
        cell_next       = cell_reg;
        cell_ld_next    = cell_ld_reg;
        steps_next      = steps_reg;
        stat_next       = stat_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_out_next = status_out_reg;
        cell_out_next   = cell_out_reg;
        len_out_next    = len_out_reg;
        used_out_next   = used_out_reg;
        steps_out_next  = steps_out_reg;
        tape_we         = 1'b0;
        tape_raddr      = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && last)
                begin
                    len_next     = ld_len;
                    ip_next      = '0;
                    head_next    = '0;
                    hm_next      = '0;
                    cell_next    = '0;
                    cell_ld_next = 1'b0;
                    steps_next   = '0;
                    if (ld_check.unbalanced || ld_check.open_left)
                    begin
                        stat_next  = ST_UNBAL;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                // cell read issued by the previous move lands here
                if (cell_ld_reg)
                begin
                    cell_next    = tape_rd_reg;
                    cell_ld_next = 1'b0;
                end
                if (steps_reg > {1'b0, step_limit_reg})
                begin
                    stat_next  = ST_LIMIT;
                    state_next = S_FIN;
                end
                else if (ip_reg >= len_reg)
                begin
                    stat_next  = ST_HALT;
                    state_next = S_FIN;
                end
                else if (!pair_pending)
                begin
                    // a pair closed by the last beat is still being written: fetch again
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                steps_next = steps_reg + 1'b1;
                ip_next    = ip_inc;
                state_next = S_FETCH;
                unique case (prog_rd)
                    OP_INC:
                        cell_next = cell_reg + 1'b1;
                    OP_DEC:
                        cell_next = cell_reg - 1'b1;
                    OP_RIGHT:
                    begin
                        if (head_reg == TW'(TAPE_DEPTH - 1))
                        begin
                            stat_next  = ST_RIGHT_EDGE;
                            state_next = S_FIN;
                        end
                        else if (head_reg == hm_reg)
                        begin
                            // fresh cell, never written this run
                            tape_we   = 1'b1;
                            head_next = head_reg + 1'b1;
                            hm_next   = head_reg + 1'b1;
                            cell_next = '0;
                        end
                        else
                        begin
                            tape_we      = 1'b1;
                            tape_raddr   = head_reg + 1'b1;
                            head_next    = head_reg + 1'b1;
                            cell_ld_next = 1'b1;
                        end
                    end
                    OP_LEFT:
                    begin
                        if (head_reg == '0)
                        begin
                            stat_next  = ST_LEFT_EDGE;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            tape_we      = 1'b1;
                            tape_raddr   = head_reg - 1'b1;
                            head_next    = head_reg - 1'b1;
                            cell_ld_next = 1'b1;
                        end
                    end
                    OP_OPEN:
                    begin
                        if (cell_reg == '0)
                            ip_next = ip_open;
                    end
                    OP_CLOSE:
                    begin
                        if (cell_reg != '0)
                            ip_next = ip_close;
                    end
                    default:
                    begin
                        // unused opcodes cost a step and do nothing
                    end
                endcase
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    status_out_next = stat_reg;
                    cell_out_next   = cell_reg;
                    len_out_next    = LEN_W'(len_reg);
                    used_out_next   = USED_W'(used_calc);
                    steps_out_next  = steps_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_limit_reg <= STEP_LIMIT_RESET;
            state_reg      <= S_IDLE;
            cell_ld_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                step_limit_reg <= cfg_wr_data;
            state_reg     <= state_next;
            cell_ld_reg   <= cell_ld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ip_reg         <= ip_next;
        len_reg        <= len_next;
        head_reg       <= head_next;
        hm_reg         <= hm_next;
        cell_reg       <= cell_next;
        steps_reg      <= steps_next;
        stat_reg       <= stat_next;
        status_out_reg <= status_out_next;
        cell_out_reg   <= cell_out_next;
        len_out_reg    <= len_out_next;
        used_out_reg   <= used_out_next;
        steps_out_reg  <= steps_out_next;
    end

    // write back the cached cell as the head leaves it
    always_ff @(posedge clk)
    begin
        if (tape_we)
            tape_mem[head_reg] <= cell_reg;
        tape_rd_reg <= tape_mem[tape_raddr];
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_out_reg;
    assign cell_value     = cell_out_reg;
    assign program_length = len_out_reg;
    assign cells_used     = used_out_reg;
    assign steps_used     = steps_out_reg;

    a_last_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && last |=> state_reg != S_IDLE)
        else $error("last beat did not start check or run");

    a_head_below_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH || state_reg == S_EXEC) |-> head_reg <= hm_reg)
        else $error("head beyond high-water mark");

    a_cell_load_in_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        cell_ld_reg |-> state_reg == S_FETCH)
        else $error("pending cell load outside fetch");

    a_unbal_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_out_reg == ST_UNBAL |->
            steps_out_reg == '0 && cell_out_reg == '0 && used_out_reg == USED_W'(1))
        else $error("unbalanced result carries run data");

endmodule
